FILE: hdl/smrr_pkg.sv
`timescale 1ns / 1ps
// Package for the round-robin SPI master sequencer.
// Word types, command, register and phase codes. No dependencies.
package smrr_pkg;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] REG_SLAVE_COUNT = 2'd0;
  localparam logic [1:0] REG_WRITE_MASK  = 2'd1;
  localparam logic [1:0] REG_READ_MASK   = 2'd2;
  localparam logic [1:0] REG_SELECT_MASK = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_SEND  = 2'd2;
  localparam logic [1:0] PH_RECV  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] slave_index;
    logic [8:0] send_count;
    logic [8:0] read_count;
    logic [7:0] byte_index;
    logic [7:0] write_byte;
    logic       rx_full;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] active_slave;
    logic       select_valid;
    logic       select_level;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_store_valid;
    logic [7:0] rx_store_index;
    logic [7:0] rx_store_byte;
    logic       transfer_done;
    logic       begin_accepted;
    logic [7:0] busy_mask;
    logic [7:0] finished_mask;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0] command;
    logic [2:0] slave_index;
    logic       in_ring;
    logic       both_zero;
    logic       load_ok;
    logic [8:0] send_total;
    logic [8:0] read_total;
    logic [7:0] byte_index;
    logic [7:0] write_byte;
    logic       rx_full;
    logic [7:0] rx_byte;
    logic [3:0] ring_size;
    logic [7:0] select_mask;
  } cls_word_t;

endpackage

FILE: hdl/smrr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/smrr_front.sv
`timescale 1ns / 1ps
// Front end: config registers, word accept, classification, two-entry queue.
// Depends on smrr_pkg.
module smrr_front import smrr_pkg::*; #(
  parameter int RING_MAX     = 8,
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       q_valid,
  output cls_word_t  q_word,
  input  logic       q_pop
);

  localparam logic [16:0] BD17 = 17'(BUFFER_DEPTH);
  localparam logic [3:0]  RMAX = 4'(RING_MAX);

  logic [3:0] slave_count;
  logic [7:0] write_mask, read_mask, select_mask;
  logic [3:0] ring_n;
  cls_word_t  cls;
  cls_word_t  fq [2];
  logic       wptr, rptr;
  logic [1:0] fill;
  logic       push;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_count <= 4'd1;
      write_mask  <= 8'hFF;
      read_mask   <= 8'hFF;
      select_mask <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLAVE_COUNT: slave_count <= cfg_data[3:0];
        REG_WRITE_MASK:  write_mask  <= cfg_data;
        REG_READ_MASK:   read_mask   <= cfg_data;
        REG_SELECT_MASK: select_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [8:0] sat(input logic [8:0] v);
    return ({8'd0, v} > BD17) ? BD17[8:0] : v;
  endfunction

  always_comb begin
    ring_n = (slave_count == 4'd0) ? 4'd1 : ((slave_count > RMAX) ? RMAX : slave_count);
    cls.command     = in_word.command;
    cls.slave_index = in_word.slave_index;
    cls.in_ring     = ({1'b0, in_word.slave_index} < ring_n);
    cls.both_zero   = (in_word.send_count == 9'd0) && (in_word.read_count == 9'd0);
    cls.load_ok     = cls.in_ring && ({9'd0, in_word.byte_index} < BD17);
    cls.send_total  = write_mask[in_word.slave_index] ? sat(in_word.send_count) : 9'd0;
    cls.read_total  = read_mask[in_word.slave_index] ? sat(in_word.read_count) : 9'd0;
    cls.byte_index  = in_word.byte_index;
    cls.write_byte  = in_word.write_byte;
    cls.rx_full     = in_word.rx_full;
    cls.rx_byte     = in_word.rx_byte;
    cls.ring_size   = ring_n;
    cls.select_mask = select_mask;
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_word   = fq[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: hdl/smrr_back.sv
`timescale 1ns / 1ps
// Back end: per-slave records, round-robin pointer, write store, result register.
// Depends on smrr_pkg and smrr_ram.
module smrr_back import smrr_pkg::*; #(
  parameter int RING_MAX = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  cls_word_t q_word,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int STORE_DEPTH = RING_MAX * 256;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [1:0] phase [8];
  logic [8:0] send_tot [8];
  logic [8:0] read_tot [8];
  logic [8:0] pos [8];
  logic [7:0] fin;
  logic [2:0] cur;
  logic       st;

  logic [1:0] phase_next [8];
  logic [8:0] send_tot_next [8];
  logic [8:0] read_tot_next [8];
  logic [8:0] pos_next [8];
  logic [7:0] fin_next;
  logic [2:0] cur_next;
  logic       st_next;

  out_word_t  res, hold, read_res;
  logic       hold_use, use_next;
  logic       produce, go, out_free;
  logic       ram_we, ram_re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] rdata;
  logic [2:0] c, adv;
  logic [8:0] p1;

  smrr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(q_word.write_byte),
    .re(ram_re), .raddr(raddr), .rdata(rdata)
  );

  assign out_free = !out_valid || out_ready;
  assign go       = q_valid && out_free && (st == ST_RUN);
  assign q_pop    = go;
  assign waddr    = AW'({q_word.slave_index, q_word.byte_index});

  always_comb begin
    phase_next    = phase;
    send_tot_next = send_tot;
    read_tot_next = read_tot;
    pos_next      = pos;
    fin_next      = fin;
    cur_next      = cur;
    st_next       = ST_RUN;
    use_next      = hold_use;
    res           = '0;
    res.active_slave = cur;
    produce       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    c  = ({1'b0, cur} >= q_word.ring_size) ? 3'd0 : cur;
    adv = ({1'b0, c} + 4'd1 >= q_word.ring_size) ? 3'd0 : c + 3'd1;
    p1 = pos[c] + 9'd1;
    raddr = AW'({c, pos[c][7:0]});
    if (st == ST_READ) begin
      produce = 1'b1;
    end else if (go) begin
      produce = 1'b1;
      case (q_word.command)
        CMD_BEGIN: begin
          res.active_slave = q_word.slave_index;
          if (q_word.in_ring && phase[q_word.slave_index] == PH_IDLE && !q_word.both_zero) begin
            send_tot_next[q_word.slave_index] = q_word.send_total;
            read_tot_next[q_word.slave_index] = q_word.read_total;
            pos_next[q_word.slave_index]      = 9'd0;
            fin_next[q_word.slave_index]      = 1'b0;
            phase_next[q_word.slave_index]    = PH_START;
            res.begin_accepted = 1'b1;
          end
        end
        CMD_LOAD: begin
          res.active_slave = q_word.slave_index;
          ram_we = q_word.load_ok;
        end
        CMD_TICK: begin
          res.active_slave = c;
          cur_next = c;
          unique case (phase[c])
            PH_START: begin
              res.select_valid = q_word.select_mask[c];
              phase_next[c] = PH_SEND;
            end
            PH_SEND: begin
              res.tx_valid = 1'b1;
              use_next = (pos[c] < send_tot[c]);
              ram_re = 1'b1;
              st_next = ST_READ;
              produce = 1'b0;
              phase_next[c] = PH_RECV;
            end
            PH_RECV: begin
              if (q_word.rx_full) begin
                if (pos[c] < read_tot[c]) begin
                  res.rx_store_valid = 1'b1;
                  res.rx_store_index = pos[c][7:0];
                  res.rx_store_byte  = q_word.rx_byte;
                end
                pos_next[c] = p1;
                if (p1 < send_tot[c] || p1 < read_tot[c]) begin
                  phase_next[c] = PH_SEND;
                end else begin
                  res.select_valid  = q_word.select_mask[c];
                  res.select_level  = q_word.select_mask[c];
                  fin_next[c]       = 1'b1;
                  phase_next[c]     = PH_IDLE;
                  res.transfer_done = 1'b1;
                  cur_next          = adv;
                end
              end
            end
            default: cur_next = adv;
          endcase
        end
        default: ;
      endcase
    end
    for (int s = 0; s < 8; s++) begin
      res.busy_mask[s] = (phase_next[s] != PH_IDLE);
    end
    res.finished_mask = fin_next;
    read_res = hold;
    read_res.tx_byte = hold_use ? rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 8; s++) begin
        phase[s]    <= PH_IDLE;
        send_tot[s] <= 9'd0;
        read_tot[s] <= 9'd0;
        pos[s]      <= 9'd0;
      end
      fin       <= 8'd0;
      cur       <= 3'd0;
      st        <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      send_tot <= send_tot_next;
      read_tot <= read_tot_next;
      pos      <= pos_next;
      fin      <= fin_next;
      cur      <= cur_next;
      st       <= st_next;
      if (produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_use <= use_next;
    if (ram_re) begin
      hold <= res;
    end
    if (produce) begin
      out_word <= (st == ST_READ) ? read_res : res;
    end
  end

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    st == ST_READ |=> st == ST_RUN) else $error("store read wait too long");
  a_no_pop_in_read: assert property (@(posedge clk) disable iff (rst)
    st == ST_READ |-> !q_pop) else $error("queue popped during store read");
  a_re_to_read: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> st == ST_READ) else $error("store read not followed");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    produce |-> (out_free || st == ST_READ)) else $error("result overwritten");

endmodule

FILE: hdl/spi_master_round_robin_sequencer_unit.sv
`timescale 1ns / 1ps
// Round-robin SPI master sequencer, top level.
// Path: queue register, then result register; a send-phase tick adds the store read.
// Throughput: one word per cycle unless stalled; a send-phase tick holds the back end.
// Two-entry queue between front and back. Reset: synchronous, all slaves idle,
// pointer zero, registers to defaults; write store contents undefined until loaded.
module spi_master_round_robin_sequencer_unit import smrr_pkg::*; #(
  parameter int NUM_SLAVES   = 8,
  parameter int BUFFER_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word
);

  localparam int RING_MAX = (NUM_SLAVES < 8) ? NUM_SLAVES : 8;

  logic      q_valid, q_pop;
  cls_word_t q_word;

  smrr_front #(.RING_MAX(RING_MAX), .BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
  );

  smrr_back #(.RING_MAX(RING_MAX)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for spi_master_round_robin_sequencer_unit.
// Needs smrr_pkg. A queue-fed driver and a monitor check each result word
// against an in-bench model of the slave ring, under random idling on both sides.
module tb_top;
  import smrr_pkg::*;

  localparam int LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_word;

  spi_master_round_robin_sequencer_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // model of the ring
  logic [1:0] phase_q [8];
  logic [8:0] send_tot [8];
  logic [8:0] read_tot [8];
  logic [8:0] byte_pos [8];
  logic       fin_q [8];
  logic [2:0] cur_slave;
  logic [7:0] tx_store [8][256];
  bit         tx_loaded [8][256];
  logic [3:0] ring_cfg;
  logic [7:0] wmask_cfg, rmask_cfg, smask_cfg;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        idle_in, idle_out, errors, cycles;
  int        sent_cnt, acc_cnt;

  function automatic int ring_len();
    if (ring_cfg == 0) return 1;
    if (ring_cfg > 8) return 8;
    return ring_cfg;
  endfunction

  function automatic logic [8:0] sat_cnt(logic [8:0] v);
    return (v > 9'd256) ? 9'd256 : v;
  endfunction

  function automatic out_word_t advance_ring(in_word_t w);
    out_word_t r;
    int n, c, p;
    logic drv;
    r = '0;
    n = ring_len();
    r.active_slave = cur_slave;
    case (w.command)
      CMD_BEGIN: begin
        r.active_slave = w.slave_index;
        if (w.slave_index < n && phase_q[w.slave_index] == PH_IDLE &&
            !(w.send_count == 0 && w.read_count == 0)) begin
          send_tot[w.slave_index] = wmask_cfg[w.slave_index] ? sat_cnt(w.send_count) : '0;
          read_tot[w.slave_index] = rmask_cfg[w.slave_index] ? sat_cnt(w.read_count) : '0;
          byte_pos[w.slave_index] = '0;
          fin_q[w.slave_index] = 1'b0;
          phase_q[w.slave_index] = PH_START;
          r.begin_accepted = 1'b1;
        end
      end
      CMD_LOAD: begin
        r.active_slave = w.slave_index;
        if (w.slave_index < n) begin
          tx_store[w.slave_index][w.byte_index] = w.write_byte;
          tx_loaded[w.slave_index][w.byte_index] = 1'b1;
        end
      end
      CMD_TICK: begin
        c = (cur_slave >= n) ? 0 : cur_slave;
        cur_slave = 3'(c);
        r.active_slave = 3'(c);
        drv = smask_cfg[c];
        case (phase_q[c])
          PH_START: begin
            r.select_valid = drv;
            phase_q[c] = PH_SEND;
          end
          PH_SEND: begin
            r.tx_valid = 1'b1;
            if (byte_pos[c] < send_tot[c]) r.tx_byte = tx_store[c][byte_pos[c][7:0]];
            phase_q[c] = PH_RECV;
          end
          PH_RECV: begin
            if (w.rx_full) begin
              p = byte_pos[c];
              if (p < read_tot[c]) begin
                r.rx_store_valid = 1'b1;
                r.rx_store_index = p[7:0];
                r.rx_store_byte = w.rx_byte;
              end
              p++;
              byte_pos[c] = 9'(p);
              if (p < send_tot[c] || p < read_tot[c]) begin
                phase_q[c] = PH_SEND;
              end else begin
                r.select_valid = drv;
                r.select_level = drv;
                fin_q[c] = 1'b1;
                phase_q[c] = PH_IDLE;
                r.transfer_done = 1'b1;
                cur_slave = 3'((c + 1 >= n) ? 0 : c + 1);
              end
            end
          end
          default: cur_slave = 3'((c + 1 >= n) ? 0 : c + 1);
        endcase
      end
      default: ;
    endcase
    for (int s = 0; s < 8; s++) begin
      r.busy_mask[s] = (phase_q[s] != PH_IDLE);
      r.finished_mask[s] = fin_q[s];
    end
    return r;
  endfunction

  // a send-phase tick must never read an unloaded entry: load it first
  task automatic queue_word(in_word_t w);
    in_word_t ld;
    int c;
    if (w.command == CMD_TICK) begin
      c = (cur_slave >= ring_len()) ? 0 : cur_slave;
      if (phase_q[c] == PH_SEND && byte_pos[c] < send_tot[c] &&
          !tx_loaded[c][byte_pos[c][7:0]]) begin
        ld = in_word_t'(48'({$urandom, $urandom}));
        ld.command = CMD_LOAD;
        ld.slave_index = 3'(c);
        ld.byte_index = byte_pos[c][7:0];
        pending_words.push_back(ld);
        expected_results.push_back(advance_ring(ld));
      end
    end
    pending_words.push_back(w);
    expected_results.push_back(advance_ring(w));
  endtask

  task automatic mk(logic [1:0] cmd, logic [2:0] si, logic [8:0] sc, logic [8:0] rc,
                    logic [7:0] bi, logic [7:0] wb, logic rf, logic [7:0] rb);
    in_word_t w;
    w = '{cmd, si, sc, rc, bi, wb, rf, rb};
    queue_word(w);
  endtask

  task automatic random_words(int count);
    in_word_t w;
    int k;
    for (int i = 0; i < count; i++) begin
      w = in_word_t'(48'({$urandom, $urandom}));
      k = $urandom_range(99);
      if (k < 50) begin
        w.command = CMD_TICK;
        w.rx_full = ($urandom_range(9) < 7);
      end else if (k < 70) begin
        w.command = CMD_BEGIN;
        if ($urandom_range(49) != 0) begin
          w.send_count = 9'($urandom_range(6));
          w.read_count = 9'($urandom_range(6));
        end
      end else if (k < 92) begin
        w.command = CMD_LOAD;
        if ($urandom_range(3) != 0) w.byte_index = 8'($urandom_range(7));
      end else begin
        w.command = ($urandom_range(1) != 0) ? CMD_NOP : CMD_TICK;
      end
      queue_word(w);
    end
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SLAVE_COUNT: ring_cfg = val[3:0];
      REG_WRITE_MASK:  wmask_cfg = val;
      REG_READ_MASK:   rmask_cfg = val;
      default:         smask_cfg = val;
    endcase
  endtask

  task automatic write_all(logic [7:0] cnt, logic [7:0] wm, logic [7:0] rm, logic [7:0] sm);
    write_reg(REG_SLAVE_COUNT, cnt);
    write_reg(REG_WRITE_MASK, wm);
    write_reg(REG_READ_MASK, rm);
    write_reg(REG_SELECT_MASK, sm);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_out);
      if (acc_cnt == sent_cnt) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_in) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    cycles++;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && in_valid && in_ready) acc_cnt++;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_word);
      end else begin
        e = expected_results.pop_front();
        if (out_word !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %h got %h", e, out_word);
        end
      end
    end
  end

  initial begin
    for (int s = 0; s < 8; s++) begin
      phase_q[s] = PH_IDLE;
      send_tot[s] = '0;
      read_tot[s] = '0;
      byte_pos[s] = '0;
      fin_q[s] = 1'b0;
      for (int b = 0; b < 256; b++) tx_loaded[s][b] = 1'b0;
    end
    cur_slave = '0;
    ring_cfg = 4'd1;
    wmask_cfg = 8'hFF;
    rmask_cfg = 8'hFF;
    smask_cfg = 8'hFF;
    idle_in = 37;
    idle_out = 63;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_all(8'd8, 8'hFF, 8'hFF, 8'hFF);
    mk(CMD_NOP, 3'd7, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    mk(CMD_LOAD, 3'd0, 9'd0, 9'd0, 8'd0, 8'hFF, 1'b0, 8'h00);
    mk(CMD_LOAD, 3'd0, 9'd0, 9'd0, 8'd1, 8'h00, 1'b0, 8'h00);
    mk(CMD_LOAD, 3'd7, 9'd0, 9'd0, 8'hFF, 8'hA5, 1'b0, 8'h00);
    mk(CMD_BEGIN, 3'd0, 9'd2, 9'd1, 8'd0, 8'd0, 1'b0, 8'h00);
    mk(CMD_BEGIN, 3'd0, 9'd1, 9'd1, 8'd0, 8'd0, 1'b0, 8'h00);
    mk(CMD_BEGIN, 3'd1, 9'd0, 9'd0, 8'd0, 8'd0, 1'b0, 8'h00);
    mk(CMD_BEGIN, 3'd2, 9'd0, 9'd3, 8'd0, 8'd0, 1'b0, 8'h00);
    mk(CMD_TICK, 3'd7, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    mk(CMD_TICK, 3'd0, 9'd0, 9'd0, 8'd0, 8'd0, 1'b1, 8'hFF);
    mk(CMD_TICK, 3'd0, 9'd0, 9'd0, 8'd0, 8'd0, 1'b0, 8'h12);
    mk(CMD_TICK, 3'd0, 9'd0, 9'd0, 8'd0, 8'd0, 1'b1, 8'hFF);
    mk(CMD_TICK, 3'd0, 9'd0, 9'd0, 8'd0, 8'd0, 1'b0, 8'h00);
    mk(CMD_TICK, 3'd0, 9'd0, 9'd0, 8'd0, 8'd0, 1'b1, 8'h00);
    for (int i = 0; i < 9; i++) mk(CMD_TICK, 3'd0, 9'd0, 9'd0, 8'd0, 8'd0, 1'b1, 8'h5A);
    drain();

    write_all(8'd15, 8'h00, 8'hFF, 8'h00);
    mk(CMD_BEGIN, 3'd5, 9'h1FF, 9'd0, 8'd0, 8'd0, 1'b0, 8'h00);
    random_words(600);
    drain();

    idle_in = 63;
    idle_out = 37;
    write_all(8'd0, 8'($urandom), 8'h00, 8'($urandom));
    random_words(150);
    drain();
    write_all(8'($urandom_range(2, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
    random_words(150);
    drain();
    random_words(200);
    drain();

    idle_in = 0;
    idle_out = 0;
    write_all(8'd8, 8'hFF, 8'hFF, 8'($urandom));
    random_words(500);
    drain();
    write_all(8'($urandom_range(1, 8)), 8'($urandom), 8'($urandom), 8'hFF);
    random_words(300);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
